// ----- design/hkr_pkg.sv -----
// ----------------------------------------------------------------------------
// hkr_pkg
// Keyword codes, keyword ROM and sizing constants for the hashed keyword
// recognizer.
// ----------------------------------------------------------------------------
`default_nettype none

package hkr_pkg;

    localparam int          DEF_MAX_KEYWORD_LEN = 4;
    localparam int          TABLE_SLOTS         = 32;
    localparam int          SLOT_W              = $clog2(TABLE_SLOTS);
    localparam int          KW_CHARS            = 4;
    localparam int          KW_LEN_W            = 3;
    localparam logic [SLOT_W-1:0] HASH_START    = SLOT_W'(21);

    typedef enum logic [3:0] {
        KW_PLUS  = 4'd0,
        KW_MINUS = 4'd1,
        KW_STAR  = 4'd2,
        KW_SLASH = 4'd3,
        KW_SWAP  = 4'd4,
        KW_ROT   = 4'd5,
        KW_POP   = 4'd6,
        KW_DUP   = 4'd7,
        KW_DROP  = 4'd8,
        KW_NIP   = 4'd9,
        KW_IF    = 4'd10,
        KW_ELSE  = 4'd11,
        KW_DONE  = 4'd12
    } t_kw_code;

    typedef struct packed {
        logic [KW_LEN_W-1:0]       len;
        t_kw_code                  code;
        logic [KW_CHARS-1:0][7:0]  text;
    } t_kw_slot;

    function automatic t_kw_slot kw_entry(
        input logic [KW_LEN_W-1:0] len,
        input t_kw_code            code,
        input logic [7:0]          c0,
        input logic [7:0]          c1,
        input logic [7:0]          c2,
        input logic [7:0]          c3
    );
        t_kw_slot e;
        e.len     = len;
        e.code    = code;
        e.text[0] = c0;
        e.text[1] = c1;
        e.text[2] = c2;
        e.text[3] = c3;
        return e;
    endfunction

    function automatic t_kw_slot kw_rom(input logic [SLOT_W-1:0] slot);
        t_kw_slot e;
        unique case (slot)
            5'd0:    e = kw_entry(3'd3, KW_NIP,   "n", "i", "p", 8'h00);
            5'd2:    e = kw_entry(3'd3, KW_ROT,   "r", "o", "t", 8'h00);
            5'd4:    e = kw_entry(3'd4, KW_DROP,  "d", "r", "o", "p");
            5'd8:    e = kw_entry(3'd4, KW_SWAP,  "s", "w", "a", "p");
            5'd10:   e = kw_entry(3'd3, KW_DUP,   "d", "u", "p", 8'h00);
            5'd14:   e = kw_entry(3'd4, KW_ELSE,  "e", "l", "s", "e");
            5'd18:   e = kw_entry(3'd2, KW_IF,    "i", "f", 8'h00, 8'h00);
            5'd21:   e = kw_entry(3'd1, KW_STAR,  "*", 8'h00, 8'h00, 8'h00);
            5'd22:   e = kw_entry(3'd1, KW_PLUS,  "+", 8'h00, 8'h00, 8'h00);
            5'd23:   e = kw_entry(3'd4, KW_DONE,  "d", "o", "n", "e");
            5'd24:   e = kw_entry(3'd1, KW_MINUS, "-", 8'h00, 8'h00, 8'h00);
            5'd26:   e = kw_entry(3'd1, KW_SLASH, "/", 8'h00, 8'h00, 8'h00);
            5'd28:   e = kw_entry(3'd3, KW_POP,   "p", "o", "p", 8'h00);
            default: e = kw_entry(3'd0, KW_PLUS,  8'h00, 8'h00, 8'h00, 8'h00);
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

// ----- design/hashed_keyword_recognizer_unit.sv -----
// ----------------------------------------------------------------------------
// hashed_keyword_recognizer_unit
// Hashes a token one character per transfer and looks the final hash up in a
// fixed keyword ROM, reporting the keyword code and a found flag.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                          Transfers
//  s_axis    in         tdata: character, tlast: last    one per token char
//  m_axis    out        tdata: keyword_code, tuser: found one per token
//
//  One character per cycle when no result stalls; the hash, store update
//  and ROM compare sit between the input register and the result register.
//  A last character's result passes the input register, then the result register.
//  Reset clears the hash to 21, the length count to zero and both valids.
//  A stalled result holds only last characters; others keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_keyword_recognizer_unit
    import hkr_pkg::*;
#(
    parameter int MAX_KEYWORD_LEN = DEF_MAX_KEYWORD_LEN
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,

    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] character
    input  wire logic       i_s_axis_tlast,   // last_char

    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [3:0] keyword_code, [7:4] zero
    output logic            o_m_axis_tuser    // found
);

    localparam int CW = $clog2(MAX_KEYWORD_LEN + 2);

    logic              r_in_valid;
    logic [7:0]        r_in_char;
    logic              r_in_last;

    logic [SLOT_W-1:0] r_hash;
    logic [CW-1:0]     r_count;
    logic [7:0]        r_store [MAX_KEYWORD_LEN];

    logic              r_out_valid;
    logic [3:0]        r_out_code;
    logic              r_out_found;

    logic              w_consume;
    logic [SLOT_W-1:0] n_hash;
    logic [CW-1:0]     n_count;
    logic [7:0]        w_cmp [KW_CHARS];
    t_kw_slot          w_slot;
    logic              w_hit;

    assign w_consume       = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_consume;

    // h*31 + c keeps only the low bits, so it is c - h modulo the slot count
    assign n_hash  = r_in_char[SLOT_W-1:0] - r_hash;
    assign n_count = (r_count <= CW'(MAX_KEYWORD_LEN)) ? r_count + CW'(1) : r_count;
    assign w_slot  = kw_rom(n_hash);

    always_comb begin
        for (int i = 0; i < KW_CHARS; i++) begin
            w_cmp[i] = (r_count == CW'(i)) ? r_in_char : r_store[i];
        end
        w_hit = (w_slot.len != '0) && (CW'(w_slot.len) == n_count);
        for (int i = 0; i < KW_CHARS; i++) begin
            if ((KW_LEN_W'(i) < w_slot.len) && (w_cmp[i] != w_slot.text[i])) begin
                w_hit = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready) begin
            r_in_char <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash  <= HASH_START;
            r_count <= '0;
        end else if (w_consume) begin
            if (r_in_last) begin
                r_hash  <= HASH_START;
                r_count <= '0;
            end else begin
                r_hash  <= n_hash;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
            if (w_consume && !r_in_last && r_count == CW'(i)) begin
                r_store[i] <= r_in_char;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_consume && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_consume && r_in_last) begin
            r_out_code  <= w_hit ? w_slot.code : 4'd0;
            r_out_found <= w_hit;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out_code};
    assign o_m_axis_tuser  = r_out_found;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_KEYWORD_LEN + 1))
        else $error("length count past saturation");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && r_in_last) |=> r_out_valid)
        else $error("last character produced no result");

    a_token_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && r_in_last) |=> (r_count == '0 && r_hash == HASH_START))
        else $error("token state not cleared after last character");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_code == 4'd0))
        else $error("miss result carries a nonzero code");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_found) |-> (r_out_code <= KW_DONE))
        else $error("keyword code out of range");

endmodule

`default_nettype wire
